// ===== hw/rtl/wst_pkg.sv =====
`default_nettype none

package wst_pkg;

  // tree geometry and number formats
  localparam int NODE_BITS   = 8;
  localparam int DEPTH       = 256;
  localparam int COUNT_BITS  = 9;
  localparam int WEIGHT_BITS = 32;
  localparam int SUM_BITS    = 40;
  localparam int FRAC_BITS   = 32;

  localparam logic [SUM_BITS-1:0]   SUM_MAX   = '1;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = COUNT_BITS'(DEPTH);

  // item kinds carried on tuser
  localparam logic OP_SET    = 1'b0;
  localparam logic OP_SELECT = 1'b1;

  // write and read requests to the subtree sum store
  typedef struct packed {
    logic                 we;
    logic [NODE_BITS-1:0] waddr;
    logic [SUM_BITS-1:0]  wdata;
    logic [NODE_BITS-1:0] raddr_a;
    logic [NODE_BITS-1:0] raddr_b;
  } sum_req_t;

endpackage

`default_nettype wire

// ===== hw/rtl/wst_sum_store.sv =====
`default_nettype none

module wst_sum_store
  import wst_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire sum_req_t            req,
  output logic [SUM_BITS-1:0]      rdata_a,
  output logic [SUM_BITS-1:0]      rdata_b
);

  logic [SUM_BITS-1:0] mem [DEPTH];
  logic [SUM_BITS-1:0] q_a;
  logic [SUM_BITS-1:0] q_b;
  logic [SUM_BITS-1:0] byp;
  logic                hit_a;
  logic                hit_b;

  // one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    q_a <= mem[req.raddr_a];
    q_b <= mem[req.raddr_b];
    byp <= req.wdata;
  end

  // remember reads that collided with the write of the same cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      hit_a <= 1'b0;
      hit_b <= 1'b0;
    end else begin
      hit_a <= req.we && (req.waddr == req.raddr_a);
      hit_b <= req.we && (req.waddr == req.raddr_b);
    end
  end

  // forward the freshly written sum over the stale read data
  assign rdata_a = hit_a ? byp : q_a;
  assign rdata_b = hit_b ? byp : q_b;

endmodule

`default_nettype wire

// ===== hw/rtl/wst_scaler.sv =====
`default_nettype none

module wst_scaler
  import wst_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 load,
  input  wire logic [SUM_BITS-1:0]  total,
  input  wire logic [FRAC_BITS-1:0] frac,
  output logic [SUM_BITS-1:0]       target
);

  localparam int HI_BITS = SUM_BITS - FRAC_BITS;

  logic [2*FRAC_BITS-1:0]       p_lo;
  logic [HI_BITS+FRAC_BITS-1:0] p_hi;
  logic [SUM_BITS:0]            acc;

  // partial products of total * frac, split at bit 32 of total
  always_ff @(posedge clk) begin
    if (load) begin
      p_lo <= total[FRAC_BITS-1:0] * frac;
      p_hi <= total[SUM_BITS-1:FRAC_BITS] * frac;
    end
  end

  // floor(total * frac / 2^32); never above total, so it fits in SUM_BITS
  assign acc    = {1'b0, p_hi} + {{(SUM_BITS+1-FRAC_BITS){1'b0}}, p_lo[2*FRAC_BITS-1:FRAC_BITS]};
  assign target = acc[SUM_BITS-1:0];

endmodule

`default_nettype wire

// ===== hw/rtl/weighted_sum_tree_selector.sv =====
`default_nettype none

// Weighted sum tree of 256 heap-indexed nodes. Node weights sit in one memory
// and subtree sums in a second, dual-read memory; both have registered reads.
// After reset both memories are cleared in a pass over all 256 nodes,
// during which no item and no write is taken. Items are handled one at a
// time. A set item updates the sums from the written node up to the root,
// as the sum update climbs one level per cycle with the newest sum forwarded
// past the memory. A select item walks down from the root, one read of both
// child sums per level. A set item whose index is at or beyond node_count
// returns its result with no update. A result waits in an output register
// while the next item is taken. Writing node_count rebuilds all sums
// bottom-up, during which no item and no further write is taken.
// Configuration must be written only while the block is idle.
module weighted_sum_tree_selector
  import wst_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  // configuration: node_count
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [8:0]  cfg_data,
  // input items
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [71:0] s_axis_tdata,  // node_index[7:0], new_weight[39:8],
                                          // random_fraction[71:40]
  input  wire logic        s_axis_tuser,  // op
  // results
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [47:0]      m_axis_tdata,  // chosen_index[7:0], total_sum[47:8]
  output logic             m_axis_tuser   // zero_total
);

  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_UPD    = 7'b0000010,
    ST_MUL    = 7'b0000100,
    ST_SCALE  = 7'b0001000,
    ST_WALK   = 7'b0010000,
    ST_RESULT = 7'b0100000,
    ST_CLEAR  = 7'b1000000
  } state_t;

  state_t st;

  // control
  logic [COUNT_BITS-1:0] active;
  logic [SUM_BITS-1:0]   total;
  logic                  rebuild;
  logic                  iss_act;
  logic                  cmp_act;
  logic [NODE_BITS-1:0]  clr_addr;

  // payload
  logic [NODE_BITS-1:0]  iss_node;
  logic [NODE_BITS-1:0]  cmp_node;
  logic                  cmp_lc_ok;
  logic                  cmp_rc_ok;
  logic [NODE_BITS-1:0]  cur;
  logic [SUM_BITS-1:0]   rem;
  logic [FRAC_BITS-1:0]  frac;
  logic [NODE_BITS-1:0]  res_chosen;

  // weight memory
  logic [WEIGHT_BITS-1:0] weight_mem [DEPTH];
  logic [WEIGHT_BITS-1:0] wt_q;

  // input field split
  logic                   in_op;
  logic [NODE_BITS-1:0]   in_index;
  logic [WEIGHT_BITS-1:0] in_weight;
  logic [FRAC_BITS-1:0]   in_frac;
  logic                   in_take;
  logic                   cfg_take;
  logic                   in_set_ok;

  assign in_op     = s_axis_tuser;
  assign in_index  = s_axis_tdata[7:0];
  assign in_weight = s_axis_tdata[39:8];
  assign in_frac   = s_axis_tdata[71:40];

  assign cfg_ready     = (st == ST_IDLE);
  assign s_axis_tready = (st == ST_IDLE) && !cfg_valid;
  assign in_take       = s_axis_tvalid && s_axis_tready;
  assign cfg_take      = cfg_valid && cfg_ready;
  assign in_set_ok     = ({1'b0, in_index} < active);

  // clamp the written count to 1..256
  logic [COUNT_BITS-1:0] active_new;
  always_comb begin
    if (cfg_data == '0) begin
      active_new = COUNT_BITS'(1);
    end else if (cfg_data > COUNT_MAX) begin
      active_new = COUNT_MAX;
    end else begin
      active_new = cfg_data;
    end
  end

  // child presence tests under the active count
  function automatic logic left_ok(input logic [NODE_BITS-1:0] n,
                                   input logic [COUNT_BITS-1:0] cnt);
    return {n, 1'b1} < cnt;
  endfunction

  function automatic logic right_ok(input logic [NODE_BITS-1:0] n,
                                    input logic [COUNT_BITS-1:0] cnt);
    logic [COUNT_BITS:0] rc;
    rc = {1'b0, n, 1'b0} + (COUNT_BITS+1)'(2);
    return rc < {1'b0, cnt};
  endfunction

  // sum store and read address selection
  sum_req_t             sreq;
  logic [SUM_BITS-1:0]  sa;
  logic [SUM_BITS-1:0]  sb;
  logic [NODE_BITS-1:0] rd_node;
  logic [NODE_BITS-1:0] cur_next;
  logic [SUM_BITS-1:0]  rem_next;
  logic                 walk_done;

  wst_sum_store u_sums (
    .clk     (clk),
    .rst     (rst),
    .req     (sreq),
    .rdata_a (sa),
    .rdata_b (sb)
  );

  // recompute of the node whose reads came back
  logic [SUM_BITS+1:0] sum_full;
  logic [SUM_BITS-1:0] sum_sat;
  always_comb begin
    sum_full = {{(SUM_BITS+2-WEIGHT_BITS){1'b0}}, wt_q}
             + {2'b00, (cmp_lc_ok ? sa : {SUM_BITS{1'b0}})}
             + {2'b00, (cmp_rc_ok ? sb : {SUM_BITS{1'b0}})};
    sum_sat  = (sum_full[SUM_BITS+1:SUM_BITS] != 2'b00) ? SUM_MAX
                                                         : sum_full[SUM_BITS-1:0];
  end

  assign rd_node = (st == ST_UPD) ? iss_node : cur_next;

  // clearing pass writes zeros, update pass writes recomputed sums
  always_comb begin
    sreq.we      = (st == ST_CLEAR) || ((st == ST_UPD) && cmp_act);
    sreq.waddr   = (st == ST_CLEAR) ? clr_addr : cmp_node;
    sreq.wdata   = (st == ST_CLEAR) ? '0 : sum_sat;
    sreq.raddr_a = {rd_node[NODE_BITS-2:0], 1'b1};
    sreq.raddr_b = {rd_node[NODE_BITS-2:0], 1'b0} + NODE_BITS'(2);
  end

  // one level of the select walk: left subtree, right subtree, own weight
  logic [SUM_BITS-1:0] rem_diff;
  always_comb begin
    rem_diff  = rem - sa;
    cur_next  = cur;
    rem_next  = rem;
    walk_done = 1'b0;
    if (st == ST_SCALE) begin
      cur_next = '0;
    end else if (st == ST_WALK) begin
      if (!left_ok(cur, active)) begin
        walk_done = 1'b1;
      end else if (rem < sa) begin
        cur_next = {cur[NODE_BITS-2:0], 1'b1};
      end else if (!right_ok(cur, active)) begin
        walk_done = 1'b1;
      end else if (rem_diff < sb) begin
        cur_next = {cur[NODE_BITS-2:0], 1'b0} + NODE_BITS'(2);
        rem_next = rem_diff;
      end else begin
        walk_done = 1'b1;
      end
    end
  end

  // scaled target for the walk
  logic [SUM_BITS-1:0] target;
  wst_scaler u_scale (
    .clk    (clk),
    .load   (st == ST_MUL),
    .total  (total),
    .frac   (frac),
    .target (target)
  );

  // weight memory: cleared after reset, written by an accepted set item
  // within node_count, read along the update path
  always_ff @(posedge clk) begin
    if (st == ST_CLEAR) begin
      weight_mem[clr_addr] <= '0;
    end else if (in_take && (in_op == OP_SET) && in_set_ok) begin
      weight_mem[in_index] <= in_weight;
    end
    wt_q <= weight_mem[iss_node];
  end

  logic out_free;
  assign out_free = !m_axis_tvalid || m_axis_tready;

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      st            <= ST_CLEAR;
      clr_addr      <= '0;
      active        <= COUNT_MAX;
      total         <= '0;
      rebuild       <= 1'b0;
      iss_act       <= 1'b0;
      cmp_act       <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if ((st == ST_RESULT) && out_free) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      case (st)
        ST_CLEAR: begin
          clr_addr <= clr_addr + NODE_BITS'(1);
          if (clr_addr == '1) begin
            st <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (cfg_take) begin
            active  <= active_new;
            rebuild <= 1'b1;
            iss_act <= 1'b1;
            st      <= ST_UPD;
          end else if (in_take) begin
            if (in_op == OP_SELECT) begin
              st <= ST_MUL;
            end else if (in_set_ok) begin
              rebuild <= 1'b0;
              iss_act <= 1'b1;
              st      <= ST_UPD;
            end else begin
              st <= ST_RESULT;
            end
          end
        end
        ST_UPD: begin
          // the issue side has already passed the root when the root completes
          cmp_act <= iss_act;
          if (iss_act && (iss_node == '0)) begin
            iss_act <= 1'b0;
          end
          if (cmp_act && (cmp_node == '0)) begin
            total <= sum_sat;
            st    <= rebuild ? ST_IDLE : ST_RESULT;
          end
        end
        ST_MUL: begin
          st <= ST_SCALE;
        end
        ST_SCALE: begin
          st <= ST_WALK;
        end
        ST_WALK: begin
          if (walk_done) begin
            st <= ST_RESULT;
          end
        end
        ST_RESULT: begin
          if (out_free) begin
            st <= ST_IDLE;
          end
        end
        default: begin
          st <= ST_IDLE;
        end
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (st)
      ST_IDLE: begin
        res_chosen <= '0;
        frac       <= in_frac;
        if (cfg_take) begin
          iss_node <= NODE_BITS'(active_new - COUNT_BITS'(1));
        end else begin
          iss_node <= in_index;
        end
      end
      ST_UPD: begin
        cmp_node  <= iss_node;
        cmp_lc_ok <= left_ok(iss_node, active);
        cmp_rc_ok <= right_ok(iss_node, active);
        if (rebuild) begin
          iss_node <= iss_node - NODE_BITS'(1);
        end else begin
          iss_node <= (iss_node - NODE_BITS'(1)) >> 1;
        end
      end
      ST_SCALE: begin
        cur <= cur_next;
        rem <= target;
      end
      ST_WALK: begin
        cur <= cur_next;
        rem <= rem_next;
        if (walk_done) begin
          res_chosen <= cur;
        end
      end
      ST_RESULT: begin
        if (out_free) begin
          m_axis_tdata <= {total, res_chosen};
          m_axis_tuser <= (total == '0);
        end
      end
      default: begin
      end
    endcase
  end

  // the walk never reaches a node outside the active count
  assert property (@(posedge clk) disable iff (rst)
    (st == ST_WALK) |-> ({1'b0, cur} < active))
    else $error("select walk left the active tree");

  // sums are written only while a clearing or update pass runs
  assert property (@(posedge clk) disable iff (rst)
    sreq.we |-> ((st == ST_UPD) || (st == ST_CLEAR)))
    else $error("sum store written outside an update pass");

  // zero flag agrees with the reported total
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tuser == (m_axis_tdata[47:8] == '0)))
    else $error("zero_total disagrees with total_sum");

  // a finished update pass leaves the root sum as the total
  assert property (@(posedge clk) disable iff (rst)
    (sreq.we && (sreq.waddr == '0)) |=> (total == $past(sreq.wdata)))
    else $error("total not updated from root sum");

endmodule

`default_nettype wire
